FILE: src/gmms_pkg.sv
// Shared types, codes and tables for the grid maze map and search block.
// No dependencies; gmms_seq and grid_maze_map_and_search import it.
package gmms_pkg;

	localparam int GRID_W_DEF = 32;
	localparam int GRID_H_DEF = 32;
	localparam logic [4:0] START_POS = 5'd11;
	localparam logic [2:0] NO_DIR = 3'd4;

	typedef enum logic [2:0] {
		FN_INIT   = 3'd0,
		FN_SETPOS = 3'd1,
		FN_ADD    = 3'd2,
		FN_ADDITM = 3'd3,
		FN_FIND   = 3'd4,
		FN_STATUS = 3'd5
	} func_t;

	localparam logic [1:0] ST_UNEXP = 2'd0;
	localparam logic [1:0] ST_EXPL  = 2'd1;
	localparam logic [1:0] ST_START = 2'd2;
	localparam logic [1:0] ST_ITEM  = 2'd3;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_INIT_WR, S_RD, S_RDW, S_WSTART, S_WSTARTW, S_VCLR,
		S_SEED, S_POP, S_POPW, S_WALL, S_NB, S_WEND, S_DONE
	} seq_state_t;

	typedef struct packed {
		logic [9:0] back_left_dist;
		logic [9:0] front_left_dist;
		logic [9:0] back_right_dist;
		logic [9:0] front_right_dist;
		logic [9:0] front_dist;
		logic [1:0] target_status;
		logic [1:0] heading;
		logic [4:0] pos_y;
		logic [4:0] pos_x;
		logic [2:0] func;
	} cmd_t;

	typedef struct packed {
		logic [10:0] path_cells;
		logic [1:0]  cell_status;
		logic [2:0]  best_direction;
	} res_t;

	// neighbour order of each walk, indexed by walk and step
	function automatic logic [1:0] walk_order(input logic [1:0] w, input logic [1:0] k);
		logic [7:0] row;
		row = 8'h00;
		case (w)
			2'd0: row = {2'd1, 2'd2, 2'd3, 2'd0};
			2'd1: row = {2'd2, 2'd3, 2'd0, 2'd1};
			2'd2: row = {2'd2, 2'd1, 2'd0, 2'd3};
			default: row = {2'd1, 2'd0, 2'd3, 2'd2};
		endcase
		return row[2*k +: 2];
	endfunction

	function automatic logic [2:0] walk_dir(input logic [1:0] w);
		logic [2:0] r;
		r = 3'd0;
		case (w)
			2'd0: r = 3'd0;
			2'd1: r = 3'd1;
			2'd2: r = 3'd3;
			default: r = 3'd2;
		endcase
		return r;
	endfunction

	// open wall bits for a heading: front, right, back always, left
	function automatic logic [3:0] open_bits(input cmd_t c, input logic [1:0] h,
			input logic [9:0] thr);
		logic [3:0] w;
		w = 4'b0000;
		w[h] = c.front_dist >= thr;
		w[h + 2'd1] = (c.front_right_dist >= thr) || (c.back_right_dist >= thr);
		w[h + 2'd3] = (c.front_left_dist >= thr) || (c.back_left_dist >= thr);
		w[h + 2'd2] = 1'b1;
		return w;
	endfunction

endpackage

FILE: src/gmms_nbr.sv
// Neighbour unit: step from a cell toward one direction and check the grid edge.
// Uses no package.
module gmms_nbr #(
	parameter int GRID_W = 32,
	parameter int GRID_H = 32
) (
	input  logic [$clog2(GRID_W)-1:0] x,
	input  logic [$clog2(GRID_H)-1:0] y,
	input  logic [1:0]                dir,
	output logic                      ok,
	output logic [$clog2(GRID_W)-1:0] nx,
	output logic [$clog2(GRID_H)-1:0] ny
);
	localparam int XW = $clog2(GRID_W);
	localparam int YW = $clog2(GRID_H);

	always_comb begin
		nx = x;
		ny = y;
		ok = 1'b0;
		case (dir)
			2'd0: begin
				ok = y != '0;
				ny = y - 1'b1;
			end
			2'd1: begin
				ok = x != XW'(GRID_W - 1);
				nx = x + 1'b1;
			end
			2'd2: begin
				ok = y != YW'(GRID_H - 1);
				ny = y + 1'b1;
			end
			default: begin
				ok = x != '0;
				nx = x - 1'b1;
			end
		endcase
	end
endmodule

FILE: src/gmms_seq.sv
// Sequencer with map, visited and stack memories; runs every function.
// Depends on gmms_pkg and gmms_nbr.
module gmms_seq #(
	parameter int GRID_W = gmms_pkg::GRID_W_DEF,
	parameter int GRID_H = gmms_pkg::GRID_H_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  gmms_pkg::cmd_t cmd,
	input  logic [9:0]     thr,
	output logic           idle,
	output logic           res_valid,
	input  logic           res_ready,
	output gmms_pkg::res_t res
);
	import gmms_pkg::*;

	localparam int CELLS = GRID_W * GRID_H;
	localparam int AW = $clog2(CELLS);
	localparam int XW = $clog2(GRID_W);
	localparam int YW = $clog2(GRID_H);
	localparam int SW = YW + XW + 2;
	localparam int SPW = AW + 1;

	seq_state_t state_q, state_d;

	logic [5:0]  map_mem [CELLS];
	logic        vis_mem [CELLS];
	logic [SW-1:0] stk_mem [CELLS];

	logic          map_we, vis_we, stk_we, vis_wd;
	logic [AW-1:0] map_wa, map_ra, vis_wa, vis_ra, stk_wa, stk_ra;
	logic [5:0]    map_wd, map_rd;
	logic          vis_rd;
	logic [SW-1:0] stk_wd, stk_rd;

	cmd_t          cmd_q;
	logic          init_q, found_q, any_q;
	logic [4:0]    rx_q, ry_q;
	logic [AW-1:0] clr_q;
	logic [SPW-1:0] sp_q, dep_q, min_q;
	logic [1:0]    wi_q, k_q, d_q;
	logic [2:0]    best_q;
	logic [1:0]    status_q;
	logic [XW-1:0] cx_q, nx_q;
	logic [YW-1:0] cy_q, ny_q;

	logic          n_ok;
	logic [XW-1:0] n_x;
	logic [YW-1:0] n_y;
	logic [AW-1:0] robot_a, query_a, n_a, cur_a;
	logic          q_in;
	logic [SPW-1:0] spm1;
	logic [XW-1:0] e_x;
	logic [YW-1:0] e_y;
	logic [1:0]    e_k;
	logic [2:0]    wdir;

	gmms_nbr #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_nbr (
		.x(cx_q), .y(cy_q), .dir(d_q), .ok(n_ok), .nx(n_x), .ny(n_y)
	);

	assign robot_a = AW'(int'(ry_q) * GRID_W + int'(rx_q));
	assign q_in = (int'(cmd_q.pos_x) < GRID_W) && (int'(cmd_q.pos_y) < GRID_H);
	assign query_a = q_in ? AW'(int'(cmd_q.pos_y) * GRID_W + int'(cmd_q.pos_x)) : robot_a;
	assign n_a = AW'(int'(ny_q) * GRID_W + int'(nx_q));
	assign spm1 = sp_q - 1'b1;
	assign e_k = stk_rd[1:0];
	assign e_x = stk_rd[2 +: XW];
	assign e_y = stk_rd[2 + XW +: YW];
	assign cur_a = AW'(int'(e_y) * GRID_W + int'(e_x));
	assign wdir = walk_dir(wi_q);

	always_ff @(posedge clk) begin
		if (map_we) map_mem[map_wa] <= map_wd;
		map_rd <= map_mem[map_ra];
		if (vis_we) vis_mem[vis_wa] <= vis_wd;
		vis_rd <= vis_mem[vis_ra];
		if (stk_we) stk_mem[stk_wa] <= stk_wd;
		stk_rd <= stk_mem[stk_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= 1'b0;
			rx_q <= START_POS;
			ry_q <= START_POS;
			clr_q <= '0;
			sp_q <= '0;
			wi_q <= '0;
			found_q <= 1'b0;
			any_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLR, S_VCLR: clr_q <= clr_q + 1'b1;
				S_IDLE: if (start) begin
					clr_q <= '0;
					init_q <= cmd.func == FN_INIT;
					wi_q <= '0;
					any_q <= 1'b0;
					if (cmd.func == FN_SETPOS && int'(cmd.pos_x) < GRID_W
							&& int'(cmd.pos_y) < GRID_H) begin
						rx_q <= cmd.pos_x;
						ry_q <= cmd.pos_y;
					end
				end
				S_WSTARTW: begin
					clr_q <= '0;
					found_q <= map_rd[1:0] == cmd_q.target_status;
				end
				S_SEED: sp_q <= SPW'(1);
				S_POPW: if (e_k == 2'd3) sp_q <= spm1;
				S_WALL: ;
				S_NB: if (map_rd[1:0] == cmd_q.target_status) begin
					found_q <= 1'b1;
				end else if (!vis_rd && int'(sp_q) < CELLS) begin
					sp_q <= sp_q + 1'b1;
				end
				S_WEND: begin
					if (found_q && (!any_q || dep_q < min_q
							|| (dep_q == min_q && wdir < best_q))) begin
						any_q <= 1'b1;
					end
					wi_q <= wi_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q <= cmd;
			best_q <= NO_DIR;
			min_q <= '0;
		end
		if (state_q == S_WSTARTW) begin
			status_q <= map_rd[1:0];
			dep_q <= '0;
		end
		if (state_q == S_INIT_WR) status_q <= ST_START;
		if (state_q == S_RDW) begin
			if (cmd_q.func == FN_STATUS && !q_in) status_q <= ST_UNEXP;
			else if ((cmd_q.func == FN_ADD || cmd_q.func == FN_ADDITM)
					&& map_rd[1:0] == ST_UNEXP)
				status_q <= (cmd_q.func == FN_ADD) ? ST_EXPL : ST_ITEM;
			else status_q <= map_rd[1:0];
		end
		if (state_q == S_POPW) begin
			cx_q <= e_x;
			cy_q <= e_y;
			k_q <= e_k;
			d_q <= walk_order(wi_q, e_k);
		end
		if (state_q == S_WALL) begin
			nx_q <= n_x;
			ny_q <= n_y;
		end
		if (state_q == S_NB && map_rd[1:0] == cmd_q.target_status)
			dep_q <= (k_q == 2'd3) ? sp_q + 1'b1 : sp_q;
		if (state_q == S_WEND && found_q && (!any_q || dep_q < min_q
				|| (dep_q == min_q && wdir < best_q))) begin
			min_q <= dep_q;
			best_q <= wdir;
		end
	end

	always_comb begin
		state_d = state_q;
		map_we = 1'b0;
		map_wa = robot_a;
		map_wd = '0;
		map_ra = robot_a;
		vis_we = 1'b0;
		vis_wa = clr_q;
		vis_wd = 1'b0;
		vis_ra = n_a;
		stk_we = 1'b0;
		stk_wa = spm1[AW-1:0];
		stk_wd = stk_rd + 1'b1;
		stk_ra = spm1[AW-1:0];
		idle = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			S_CLR: begin
				map_we = 1'b1;
				map_wa = clr_q;
				if (int'(clr_q) == CELLS - 1) state_d = init_q ? S_INIT_WR : S_IDLE;
			end
			S_IDLE: begin
				idle = 1'b1;
				if (start) begin
					case (cmd.func)
						FN_INIT: state_d = S_CLR;
						FN_FIND: state_d = S_WSTART;
						default: state_d = S_RD;
					endcase
				end
			end
			S_INIT_WR: begin
				map_we = 1'b1;
				map_wd = {open_bits(cmd_q, 2'd0, thr) & 4'b1011, ST_START};
				state_d = S_DONE;
			end
			S_RD: begin
				map_ra = (cmd_q.func == FN_STATUS) ? query_a : robot_a;
				state_d = S_RDW;
			end
			S_RDW: begin
				if ((cmd_q.func == FN_ADD || cmd_q.func == FN_ADDITM)
						&& map_rd[1:0] == ST_UNEXP) begin
					map_we = 1'b1;
					map_wd = {map_rd[5:2] | open_bits(cmd_q, cmd_q.heading, thr),
						(cmd_q.func == FN_ADD) ? ST_EXPL : ST_ITEM};
				end
				state_d = S_DONE;
			end
			S_WSTART: state_d = S_WSTARTW;
			S_WSTARTW: state_d = (map_rd[1:0] == cmd_q.target_status) ? S_WEND : S_VCLR;
			S_VCLR: begin
				vis_we = 1'b1;
				if (int'(clr_q) == CELLS - 1) state_d = S_SEED;
			end
			S_SEED: begin
				vis_we = 1'b1;
				vis_wa = robot_a;
				vis_wd = 1'b1;
				stk_we = 1'b1;
				stk_wa = '0;
				stk_wd = {YW'(ry_q), XW'(rx_q), 2'b00};
				state_d = S_POP;
			end
			S_POP: state_d = S_POPW;
			S_POPW: begin
				stk_we = e_k != 2'd3;
				map_ra = cur_a;
				state_d = S_WALL;
			end
			S_WALL: begin
				map_ra = AW'(int'(n_y) * GRID_W + int'(n_x));
				vis_ra = AW'(int'(n_y) * GRID_W + int'(n_x));
				if (map_rd[2 + d_q] && n_ok) state_d = S_NB;
				else state_d = (sp_q != '0) ? S_POP : S_WEND;
			end
			S_NB: begin
				if (map_rd[1:0] == cmd_q.target_status) begin
					state_d = S_WEND;
				end else if (vis_rd) begin
					state_d = (sp_q != '0) ? S_POP : S_WEND;
				end else begin
					vis_we = 1'b1;
					vis_wa = n_a;
					vis_wd = 1'b1;
					stk_we = int'(sp_q) < CELLS;
					stk_wa = sp_q[AW-1:0];
					stk_wd = {ny_q, nx_q, 2'b00};
					state_d = S_POP;
				end
			end
			S_WEND: state_d = (wi_q == 2'd3) ? S_DONE : S_WSTART;
			S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign res.best_direction = best_q;
	assign res.cell_status = status_q;
	assign res.path_cells = 11'(min_q);
endmodule

FILE: src/grid_maze_map_and_search.sv
// Grid maze map and search. Set position, add cell, read status and unused
// codes do one map read and at most one write; init clears the map, then writes
// the start cell; find runs 4 walks, each a visited clear and a stack search,
// both skipped when the robot cell has the target status. One word at a time.
// Reset: asynchronous; a clearing pass over all GRID_W*GRID_H map cells follows,
// with s_tready low; configuration writes are taken throughout.
module grid_maze_map_and_search #(
	parameter int GRID_W = gmms_pkg::GRID_W_DEF,
	parameter int GRID_H = gmms_pkg::GRID_H_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// pos_x, pos_y, heading, target_status, front_dist, front_right_dist,
	// back_right_dist, front_left_dist, back_left_dist
	input  logic [63:0] s_tdata,
	// func
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// best_direction, cell_status, path_cells
	output logic [15:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import gmms_pkg::*;

	cmd_t       cmd;
	res_t       res;
	logic       idle, res_valid, res_ready;
	logic [9:0] thr_q;
	logic       m_tvalid_q;
	logic [15:0] m_tdata_q;

	assign cmd = {s_tdata, s_tuser};
	assign s_tready = idle;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {22'b0, thr_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
			thr_q <= pwdata[9:0];
		end
	end

	gmms_seq #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_seq (
		.clk(clk), .arst_n(arst_n), .start(s_tvalid && s_tready), .cmd(cmd),
		.thr(thr_q), .idle(idle), .res_valid(res_valid), .res_ready(res_ready),
		.res(res)
	);

	// hold the result word until taken
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) m_tdata_q <= res;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
endmodule

FILE: src/gmms_chk.sv
// Port-level checks for the grid maze block, bound to its top level.
// Depends on grid_maze_map_and_search.
module gmms_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready again right after accept");
	a_dir: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] <= 3'd4)
		else $error("direction code out of range");
	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == 3'd4 |-> m_tdata[15:5] == 11'd0)
		else $error("path count without a direction");
endmodule

bind grid_maze_map_and_search gmms_chk u_chk (.*);
